>>> sv/npf_pkg.sv
`timescale 1ns / 1ps
// npf_pkg: shared types and constants for the near pair finder.
// No dependencies; used by the interfaces and every module of the block.
package npf_pkg;

  localparam int COORD_W = 16;
  localparam int IDX_W   = 6;
  localparam int CNT_W   = 7;
  localparam int THR_W   = 24;
  localparam int SQ_W    = 34;
  localparam int D2_W    = 35;

  localparam logic [THR_W-1:0] THR_RESET = 24'd16384;  // 4.0 A^2 in 1/4096 units

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } atom_t;

  // slot travelling into the distance unit
  typedef struct packed {
    logic             vld;    // slot occupied
    logic             entry;  // compare against a live stored atom
    logic             fin;    // end-of-scan marker
    logic [IDX_W-1:0] idx;
  } tok_t;

  // slot leaving the distance unit
  typedef struct packed {
    logic             vld;
    logic             hit;
    logic             fin;
    logic [IDX_W-1:0] idx;
  } hit_t;

  typedef struct packed {
    logic [IDX_W-1:0] earlier_index;
    logic [IDX_W-1:0] later_index;
    logic             last_of_run;
    logic             overflow;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_OVF
  } state_t;

endpackage

>>> sv/npf_ifs.sv
`timescale 1ns / 1ps
// Channel interfaces of the near pair finder: atom input, pair output, config write.
// Depends on npf_pkg.
interface npf_atom_if;
  logic                          valid;
  logic                          ready;
  logic                          start_set;
  logic signed [npf_pkg::COORD_W-1:0] x_coord;
  logic signed [npf_pkg::COORD_W-1:0] y_coord;
  logic signed [npf_pkg::COORD_W-1:0] z_coord;

  modport source (output valid, start_set, x_coord, y_coord, z_coord, input ready);
  modport sink   (input valid, start_set, x_coord, y_coord, z_coord, output ready);
endinterface

interface npf_pair_if;
  logic                        valid;
  logic                        ready;
  logic [npf_pkg::IDX_W-1:0]   earlier_index;
  logic [npf_pkg::IDX_W-1:0]   later_index;
  logic                        last_of_run;
  logic                        overflow;

  modport source (output valid, earlier_index, later_index, last_of_run, overflow,
                  input ready);
  modport sink   (input valid, earlier_index, later_index, last_of_run, overflow,
                  output ready);
endinterface

interface npf_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [npf_pkg::THR_W-1:0]   dist2_threshold;

  modport source (output valid, dist2_threshold, input ready);
  modport sink   (input valid, dist2_threshold, output ready);
endinterface

>>> sv/npf_cell.sv
`timescale 1ns / 1ps
// npf_cell: one slot of the rotating atom ring.
// Depends on npf_pkg.
module npf_cell (
  input  logic           clk,
  input  logic           shift,
  input  logic           load,
  input  npf_pkg::atom_t load_atom,
  input  npf_pkg::atom_t nb_atom,
  output npf_pkg::atom_t atom
);
  import npf_pkg::*;

  atom_t atom_reg;

  // load wins: it only happens after a full rotation, never with shift
  always_ff @(posedge clk) begin
    if (load) begin
      atom_reg <= load_atom;
    end else if (shift) begin
      atom_reg <= nb_atom;
    end
  end

  assign atom = atom_reg;

endmodule

>>> sv/npf_dist.sv
`timescale 1ns / 1ps
// npf_dist: squared distance and threshold compare, one register stage.
// Depends on npf_pkg.
module npf_dist (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic [npf_pkg::THR_W-1:0] thr,
  input  npf_pkg::atom_t            probe,
  input  npf_pkg::atom_t            stored,
  input  npf_pkg::tok_t             tok_in,
  output npf_pkg::hit_t             hit_out
);
  import npf_pkg::*;

  logic signed [COORD_W:0] dx, dy, dz;
  logic signed [SQ_W-1:0]  px, py, pz;
  logic [SQ_W-1:0]         sx, sy, sz;
  tok_t                    tok_q;
  logic [D2_W-1:0]         d2;

  always_comb begin
    dx = {probe.x[COORD_W-1], probe.x} - {stored.x[COORD_W-1], stored.x};
    dy = {probe.y[COORD_W-1], probe.y} - {stored.y[COORD_W-1], stored.y};
    dz = {probe.z[COORD_W-1], probe.z} - {stored.z[COORD_W-1], stored.z};
    px = dx * dx;
    py = dy * dy;
    pz = dz * dz;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx <= unsigned'(px);
      sy <= unsigned'(py);
      sz <= unsigned'(pz);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_q <= '0;
    end else if (en) begin
      tok_q <= tok_in;
    end
  end

  // exact: squares are non-negative and fit 34 bits, sum fits 35
  assign d2 = D2_W'(sx) + D2_W'(sy) + D2_W'(sz);

  always_comb begin
    hit_out.vld = tok_q.vld;
    hit_out.hit = tok_q.vld && tok_q.entry && (d2 < D2_W'(thr));
    hit_out.fin = tok_q.fin;
    hit_out.idx = tok_q.idx;
  end

endmodule

>>> sv/near_pair_finder.sv
`timescale 1ns / 1ps
// near_pair_finder: top level. Each atom goes through accept, one full ring turn, end marker
// and distance stage before the next atom is taken, and waits longer while the output stalls.
// An atom that meets a full store gets an overflow item instead of a scan. Reset (rst,
// synchronous) empties the store count, restores the threshold to 16384, idles the control;
// ring contents stay.
// Depends on npf_pkg, npf_ifs, npf_cell, npf_dist.
module near_pair_finder #(
  parameter int MAX_ATOMS = 64
) (
  input  logic        clk,
  input  logic        rst,
  npf_atom_if.sink    atom_in,
  npf_pair_if.source  pair_out,
  npf_cfg_if.sink     cfg
);
  import npf_pkg::*;

  // Ring of MAX_ATOMS cells. During a scan the ring shifts toward cell 0 once per
  // cycle while the output is not stalled, so cell 0 presents stored atoms 0, 1, 2 ... in
  // order to the distance unit. After exactly MAX_ATOMS shifts every atom is back in its
  // home cell and the new atom is loaded into cell [count].

  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  scan_cnt, scan_cnt_next;
  logic [IDX_W-1:0]  later, later_next;
  atom_t             probe, probe_next;
  logic [THR_W-1:0]  thr;
  res_t              out_res, out_res_next;
  logic              out_v, out_v_next;
  logic [IDX_W-1:0]  pend_idx, pend_idx_next;
  logic              pend_v, pend_v_next;

  logic              adv;        // pipeline may move: output slot free this cycle
  logic              accept;
  logic              shift;
  logic              store_new;
  logic [CNT_W-1:0]  cnt_eff;
  tok_t              tok;
  hit_t              hit;
  atom_t             ring [MAX_ATOMS];
  atom_t             new_atom;

  assign adv    = !out_v || pair_out.ready;
  assign accept = atom_in.valid && atom_in.ready;
  assign atom_in.ready = (state == ST_IDLE);
  assign cfg.ready     = 1'b1;

  assign new_atom.x = atom_in.x_coord;
  assign new_atom.y = atom_in.y_coord;
  assign new_atom.z = atom_in.z_coord;

  // ---------------- atom ring ----------------
  for (genvar i = 0; i < MAX_ATOMS; i++) begin : g_cell
    npf_cell u_cell (
      .clk       (clk),
      .shift     (shift),
      .load      (store_new && (count == CNT_W'(i))),
      .load_atom (probe),
      .nb_atom   (ring[(i + 1) % MAX_ATOMS]),
      .atom      (ring[i])
    );
  end

  // ---------------- distance unit ----------------
  npf_dist u_dist (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .thr     (thr),
    .probe   (probe),
    .stored  (ring[0]),
    .tok_in  (tok),
    .hit_out (hit)
  );

  // ---------------- threshold register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg.valid && cfg.ready) begin
      thr <= cfg.dist2_threshold;
    end
  end

  // ---------------- control ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      scan_cnt <= '0;
      out_v    <= 1'b0;
      pend_v   <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      scan_cnt <= scan_cnt_next;
      out_v    <= out_v_next;
      pend_v   <= pend_v_next;
    end
  end

  always_ff @(posedge clk) begin
    later    <= later_next;
    probe    <= probe_next;
    out_res  <= out_res_next;
    pend_idx <= pend_idx_next;
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    scan_cnt_next = scan_cnt;
    later_next    = later;
    probe_next    = probe;
    out_res_next  = out_res;
    out_v_next    = out_v && !pair_out.ready;
    pend_idx_next = pend_idx;
    pend_v_next   = pend_v;
    tok           = '0;
    shift         = 1'b0;
    store_new     = 1'b0;
    cnt_eff       = atom_in.start_set ? '0 : count;

    // Each hit is held back one step so the final one can carry last_of_run.
    if (adv && hit.vld) begin
      if (hit.fin) begin
        if (pend_v) begin
          out_res_next = '{earlier_index: pend_idx, later_index: later,
                           last_of_run: 1'b1, overflow: 1'b0};
          out_v_next   = 1'b1;
        end
        pend_v_next = 1'b0;
      end else if (hit.hit) begin
        if (pend_v) begin
          out_res_next = '{earlier_index: pend_idx, later_index: later,
                           last_of_run: 1'b0, overflow: 1'b0};
          out_v_next   = 1'b1;
        end
        pend_idx_next = hit.idx;
        pend_v_next   = 1'b1;
      end
    end

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          count_next    = cnt_eff;
          probe_next    = new_atom;
          later_next    = cnt_eff[IDX_W-1:0];
          scan_cnt_next = '0;
          state_next    = (cnt_eff == CNT_W'(MAX_ATOMS)) ? ST_OVF : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (adv) begin
          if (scan_cnt < CNT_W'(MAX_ATOMS)) begin
            tok.vld       = 1'b1;
            tok.entry     = (scan_cnt < count);
            tok.idx       = scan_cnt[IDX_W-1:0];
            shift         = 1'b1;
            scan_cnt_next = scan_cnt + 1'b1;
          end else begin
            tok.vld    = 1'b1;
            tok.fin    = 1'b1;
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        // end marker leaves the distance stage: ring is home, store the atom
        if (adv && hit.vld && hit.fin) begin
          store_new  = 1'b1;
          count_next = count + 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_OVF: begin
        if (adv) begin
          out_res_next = '{earlier_index: '0, later_index: '0,
                           last_of_run: 1'b1, overflow: 1'b1};
          out_v_next   = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign pair_out.valid         = out_v;
  assign pair_out.earlier_index = out_res.earlier_index;
  assign pair_out.later_index   = out_res.later_index;
  assign pair_out.last_of_run   = out_res.last_of_run;
  assign pair_out.overflow      = out_res.overflow;

`ifndef NO_ASSERTIONS
  a_ovf_last: assert property (@(posedge clk) disable iff (rst)
    out_v && out_res.overflow |-> out_res.last_of_run)
    else $error("overflow item without last_of_run");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    out_v && !out_res.overflow |-> out_res.earlier_index < out_res.later_index)
    else $error("pair with earlier index not below later index");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !pend_v && !hit.vld)
    else $error("idle with work left in flight");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ATOMS) && scan_cnt <= CNT_W'(MAX_ATOMS))
    else $error("count or scan counter out of range");

  a_store_grows: assert property (@(posedge clk) disable iff (rst)
    store_new |=> count == $past(count) + 1'b1)
    else $error("store count did not advance after storing an atom");
`endif

endmodule
